// ----- src/grid_border_tile_classifier_core_assert.svh -----
// Assertion macros for the border tile classifier.
// Each macro takes a label, the clock, the reset that disables the check,
// an antecedent and a consequent.
`ifndef GRID_BORDER_TILE_CLASSIFIER_CORE_ASSERT_SVH
`define GRID_BORDER_TILE_CLASSIFIER_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// Consequent must hold in the same cycle.
`define GBTC_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gbtc assertion failed (same cycle)");

// Consequent must hold in the next cycle.
`define GBTC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gbtc assertion failed (next cycle)");

`else

`define GBTC_ASSERT_IMPL(label, clk, rst, ante, cons)
`define GBTC_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ----- src/gbtc_pkg.sv -----
package gbtc_pkg;

   // Geometry defaults and field widths
   localparam int MAX_WIDTH_DEFAULT = 32;
   localparam int QUEUE_DEPTH_DEFAULT = 2;
   localparam int CFG_W_BITS = 6;
   localparam int CFG_H_BITS = 11;
   localparam int ROW_BITS = 10;
   localparam int TILE_BITS = 4;
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS = 11;

   localparam logic [CFG_H_BITS-1:0] HEIGHT_LIMIT = 11'd1024;
   localparam logic [CFG_W_BITS-1:0] FRAME_WIDTH_RESET = 6'd32;
   localparam logic [CFG_H_BITS-1:0] FRAME_HEIGHT_RESET = 11'd32;

   // Configuration register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_WIDTH = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_HEIGHT = 1'd1;

   // Tile codes
   localparam logic [TILE_BITS-1:0] TILE_EMPTY = 4'd0;
   localparam logic [TILE_BITS-1:0] TILE_FLOOR = 4'd1;
   localparam logic [TILE_BITS-1:0] TILE_N = 4'd2;
   localparam logic [TILE_BITS-1:0] TILE_E = 4'd3;
   localparam logic [TILE_BITS-1:0] TILE_S = 4'd4;
   localparam logic [TILE_BITS-1:0] TILE_W = 4'd5;
   localparam logic [TILE_BITS-1:0] TILE_NW = 4'd6;
   localparam logic [TILE_BITS-1:0] TILE_NE = 4'd7;
   localparam logic [TILE_BITS-1:0] TILE_SE = 4'd8;
   localparam logic [TILE_BITS-1:0] TILE_SW = 4'd9;

   // Empty-neighbor mask bits: NW, N, NE, E, SE, S, SW, W
   localparam logic [7:0] M_NW = 8'h01;
   localparam logic [7:0] M_N = 8'h02;
   localparam logic [7:0] M_NE = 8'h04;
   localparam logic [7:0] M_E = 8'h08;
   localparam logic [7:0] M_SE = 8'h10;
   localparam logic [7:0] M_S = 8'h20;
   localparam logic [7:0] M_SW = 8'h40;
   localparam logic [7:0] M_W = 8'h80;
   localparam logic [7:0] M_CORNER_NW = 8'h83;
   localparam logic [7:0] M_CORNER_NE = 8'h0E;
   localparam logic [7:0] M_CORNER_SE = 8'h38;
   localparam logic [7:0] M_CORNER_SW = 8'hE0;

   // Control part of one job handed from front to back
   typedef struct packed {
      logic                 has_a;   // result for the column left of the new cell
      logic [TILE_BITS-1:0] code_a;
      logic                 has_b;   // result for the last column at row end
      logic [TILE_BITS-1:0] code_b;
      logic                 flush;   // walk the final row after a and b
      logic                 up_ok;   // row above the final row lies inside the frame
   } job_ctrl_type;

   // Outer corners first, then lone diagonals, then edges.
   function automatic logic [TILE_BITS-1:0] tile_from_mask(logic center, logic [7:0] m);
      logic [TILE_BITS-1:0] t;
      if (!center) t = TILE_EMPTY;
      else if ((m & M_CORNER_NW) == M_CORNER_NW) t = TILE_NW;
      else if ((m & M_CORNER_NE) == M_CORNER_NE) t = TILE_NE;
      else if ((m & M_CORNER_SE) == M_CORNER_SE) t = TILE_SE;
      else if ((m & M_CORNER_SW) == M_CORNER_SW) t = TILE_SW;
      else if (m == M_NW) t = TILE_SE;
      else if (m == M_NE) t = TILE_SW;
      else if (m == M_SE) t = TILE_NW;
      else if (m == M_SW) t = TILE_NE;
      else if ((m & M_N) != 8'h00) t = TILE_N;
      else if ((m & M_E) != 8'h00) t = TILE_E;
      else if ((m & M_S) != 8'h00) t = TILE_S;
      else if ((m & M_W) != 8'h00) t = TILE_W;
      else t = TILE_FLOOR;
      return t;
   endfunction

endpackage

// ----- src/gbtc_classify.sv -----
module gbtc_classify #(
   parameter int MAX_WIDTH = gbtc_pkg::MAX_WIDTH_DEFAULT
) (
   input  logic [MAX_WIDTH-1:0]                               up_row,
   input  logic [MAX_WIDTH-1:0]                               mid_row,
   input  logic [MAX_WIDTH-1:0]                               lo_row,
   input  logic                                               up_ok,
   input  logic                                               lo_ok,
   input  logic [((MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1)-1:0] col,
   input  logic [$clog2(MAX_WIDTH + 1)-1:0]                   width,
   output logic [gbtc_pkg::TILE_BITS-1:0]                     tile_code
);

   localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int XW = ((CW + 1) > WW) ? (CW + 1) : WW;

   logic [CW-1:0] col_l;
   logic [CW:0]   col_r;
   logic          left_ok;
   logic          right_ok;
   logic          center_ok;
   logic          u_l, u_c, u_r, m_l, m_c, m_r, l_l, l_c, l_r;
   logic [7:0]    empty_mask;

   always_comb begin
      col_l     = col - CW'(1);
      col_r     = {1'b0, col} + (CW + 1)'(1);
      left_ok   = (col != '0);
      right_ok  = (XW'(col_r) < XW'(width));
      center_ok = (XW'(col) < XW'(width));

      u_l = up_ok & left_ok & up_row[col_l];
      u_c = up_ok & center_ok & up_row[col];
      u_r = up_ok & right_ok & up_row[col_r[CW-1:0]];
      m_l = left_ok & mid_row[col_l];
      m_c = center_ok & mid_row[col];
      m_r = right_ok & mid_row[col_r[CW-1:0]];
      l_l = lo_ok & left_ok & lo_row[col_l];
      l_c = lo_ok & center_ok & lo_row[col];
      l_r = lo_ok & right_ok & lo_row[col_r[CW-1:0]];

      empty_mask = ~{m_l, l_l, l_c, l_r, m_r, u_r, u_c, u_l};
      tile_code  = gbtc_pkg::tile_from_mask(m_c, empty_mask);
   end

endmodule

// ----- src/gbtc_front.sv -----
module gbtc_front #(
   parameter int MAX_WIDTH = gbtc_pkg::MAX_WIDTH_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_push,
   input  logic                                  req_is_floor,
   input  logic                                  req_frame_start,
   input  logic                                  csr_wen,
   input  logic [gbtc_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [gbtc_pkg::CSR_DATA_BITS-1:0]    csr_wdata,
   input  logic                                  job_full,
   output logic                                  job_push,
   output gbtc_pkg::job_ctrl_type                job_ctrl,
   output logic [MAX_WIDTH-1:0]                  job_up_row,
   output logic [MAX_WIDTH-1:0]                  job_mid_row,
   output logic [$clog2(MAX_WIDTH + 1)-1:0]      width_eff
);

   localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int CMPW = (WW > gbtc_pkg::CFG_W_BITS) ? WW : gbtc_pkg::CFG_W_BITS;
   localparam int RB = gbtc_pkg::ROW_BITS;

   logic [gbtc_pkg::CFG_W_BITS-1:0] frame_width_ff, frame_width_in;
   logic [gbtc_pkg::CFG_H_BITS-1:0] frame_height_ff, frame_height_in;
   logic [CW-1:0]        col_ff, col_in;
   logic [RB-1:0]        row_ff, row_in;
   logic [MAX_WIDTH-1:0] upper_ff, upper_in;
   logic [MAX_WIDTH-1:0] middle_ff, middle_in;
   logic [MAX_WIDTH-1:0] lower_ff, lower_in;

   logic [gbtc_pkg::CFG_H_BITS-1:0] height_eff;
   logic [WW-1:0]        width_m1;
   logic [RB-1:0]        height_m1;
   logic [CW-1:0]        col_base, col_cur, col_left;
   logic [RB-1:0]        row_base, row_cur;
   logic                 row_end, frame_end;
   logic                 accept;
   logic [MAX_WIDTH-1:0] lower_next;
   logic [gbtc_pkg::TILE_BITS-1:0] code_a, code_b;

   // Clamp register values to the legal frame.
   always_comb begin
      if (frame_width_ff == '0) width_eff = WW'(1);
      else if (CMPW'(frame_width_ff) > CMPW'(MAX_WIDTH)) width_eff = WW'(MAX_WIDTH);
      else width_eff = WW'(frame_width_ff);

      if (frame_height_ff == '0) height_eff = gbtc_pkg::CFG_H_BITS'(1);
      else if (frame_height_ff > gbtc_pkg::HEIGHT_LIMIT) height_eff = gbtc_pkg::HEIGHT_LIMIT;
      else height_eff = frame_height_ff;

      width_m1  = width_eff - WW'(1);
      height_m1 = RB'(height_eff - gbtc_pkg::CFG_H_BITS'(1));
   end

   // Position of the incoming cell, pulled back into a shrunk frame.
   always_comb begin
      col_base  = req_frame_start ? '0 : col_ff;
      row_base  = req_frame_start ? '0 : row_ff;
      col_cur   = (WW'(col_base) > width_m1) ? CW'(width_m1) : col_base;
      row_cur   = (row_base > height_m1) ? height_m1 : row_base;
      col_left  = col_cur - CW'(1);
      row_end   = (WW'(col_cur) == width_m1);
      frame_end = row_end && (row_cur == height_m1);
      accept    = req_push && !job_full;

      lower_next          = lower_ff;
      lower_next[col_cur] = req_is_floor;
   end

   gbtc_classify #(.MAX_WIDTH(MAX_WIDTH)) u_cls_a (
      .up_row    (upper_ff),
      .mid_row   (middle_ff),
      .lo_row    (lower_next),
      .up_ok     (row_cur > RB'(1)),
      .lo_ok     (1'b1),
      .col       (col_left),
      .width     (width_eff),
      .tile_code (code_a)
   );

   gbtc_classify #(.MAX_WIDTH(MAX_WIDTH)) u_cls_b (
      .up_row    (upper_ff),
      .mid_row   (middle_ff),
      .lo_row    (lower_next),
      .up_ok     (row_cur > RB'(1)),
      .lo_ok     (1'b1),
      .col       (col_cur),
      .width     (width_eff),
      .tile_code (code_b)
   );

   always_comb begin
      job_ctrl.has_a  = (row_cur != '0) && (col_cur != '0);
      job_ctrl.code_a = code_a;
      job_ctrl.has_b  = (row_cur != '0) && row_end;
      job_ctrl.code_b = code_b;
      job_ctrl.flush  = frame_end;
      job_ctrl.up_ok  = (row_cur != '0);
      job_up_row      = middle_ff;
      job_mid_row     = lower_next;
      job_push        = accept && (job_ctrl.has_a || job_ctrl.has_b || job_ctrl.flush);
   end

   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      col_in          = col_ff;
      row_in          = row_ff;
      upper_in        = upper_ff;
      middle_in       = middle_ff;
      lower_in        = lower_ff;

      if (csr_wen) begin
         case (csr_index)
            gbtc_pkg::CSR_FRAME_WIDTH: begin
               frame_width_in = csr_wdata[gbtc_pkg::CFG_W_BITS-1:0];
            end
            gbtc_pkg::CSR_FRAME_HEIGHT: begin
               frame_height_in = csr_wdata[gbtc_pkg::CFG_H_BITS-1:0];
            end
            default: begin
            end
         endcase
      end

      if (accept) begin
         lower_in = lower_next;
         if (row_end) begin
            // Shift the row window down one row.
            upper_in  = middle_ff;
            middle_in = lower_next;
            col_in    = '0;
            row_in    = frame_end ? '0 : row_cur + RB'(1);
         end else begin
            col_in = col_cur + CW'(1);
            row_in = row_cur;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= gbtc_pkg::FRAME_WIDTH_RESET;
         frame_height_ff <= gbtc_pkg::FRAME_HEIGHT_RESET;
         col_ff          <= '0;
         row_ff          <= '0;
         upper_ff        <= '0;
         middle_ff       <= '0;
         lower_ff        <= '0;
      end else begin
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
         col_ff          <= col_in;
         row_ff          <= row_in;
         upper_ff        <= upper_in;
         middle_ff       <= middle_in;
         lower_ff        <= lower_in;
      end
   end

endmodule

// ----- src/gbtc_job_queue.sv -----
module gbtc_job_queue #(
   parameter int DATA_BITS = 8,
   parameter int DEPTH     = gbtc_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  logic [DATA_BITS-1:0] wdata,
   input  logic                 pop,
   output logic [DATA_BITS-1:0] rdata,
   output logic                 full,
   output logic                 empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int NW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
   localparam logic [NW-1:0] DEPTH_N = NW'(DEPTH);

   logic [DATA_BITS-1:0] entry_ff [DEPTH];
   logic [PW-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0]        count_ff, count_in;

   assign full  = (count_ff == DEPTH_N);
   assign empty = (count_ff == '0);
   assign rdata = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PW'(1);
      if (pop)  rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PW'(1);
      if (push && !pop) count_in = count_ff + NW'(1);
      else if (pop && !push) count_in = count_ff - NW'(1);
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= wdata;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- src/gbtc_back.sv -----
module gbtc_back #(
   parameter int MAX_WIDTH = gbtc_pkg::MAX_WIDTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              job_empty,
   input  gbtc_pkg::job_ctrl_type            job_ctrl,
   input  logic [MAX_WIDTH-1:0]              job_up_row,
   input  logic [MAX_WIDTH-1:0]              job_mid_row,
   input  logic [$clog2(MAX_WIDTH + 1)-1:0]  width_eff,
   output logic                              job_pop,
   input  logic                              rsp_pop,
   output logic                              rsp_empty,
   output logic [gbtc_pkg::TILE_BITS-1:0]    rsp_tile_code,
   output logic                              rsp_burst_last,
   output logic                              rsp_frame_last
);

   localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int WW = $clog2(MAX_WIDTH + 1);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_A     = 4'b0010,
      ST_B     = 4'b0100,
      ST_FLUSH = 4'b1000
   } back_state_type;

   back_state_type         state_ff, state_in;
   gbtc_pkg::job_ctrl_type ctrl_ff, ctrl_in;
   logic [MAX_WIDTH-1:0]   up_ff, up_in;
   logic [MAX_WIDTH-1:0]   mid_ff, mid_in;
   logic [CW-1:0]          x_ff, x_in;
   logic                   out_valid_ff, out_valid_in;
   logic [gbtc_pkg::TILE_BITS-1:0] out_code_ff, out_code_in;
   logic                   out_burst_ff, out_burst_in;
   logic                   out_frame_ff, out_frame_in;

   logic [WW-1:0]          width_m1;
   logic [gbtc_pkg::TILE_BITS-1:0] flush_code, cur_code;
   logic                   x_last, is_last, emit, take;

   gbtc_classify #(.MAX_WIDTH(MAX_WIDTH)) u_cls_flush (
      .up_row    (up_ff),
      .mid_row   (mid_ff),
      .lo_row    (mid_ff),
      .up_ok     (ctrl_ff.up_ok),
      .lo_ok     (1'b0),
      .col       (x_ff),
      .width     (width_eff),
      .tile_code (flush_code)
   );

   always_comb begin
      width_m1 = width_eff - WW'(1);
      x_last   = (WW'(x_ff) == width_m1);
      case (state_ff)
         ST_A: begin
            cur_code = ctrl_ff.code_a;
            is_last  = !ctrl_ff.has_b && !ctrl_ff.flush;
         end
         ST_B: begin
            cur_code = ctrl_ff.code_b;
            is_last  = !ctrl_ff.flush;
         end
         ST_FLUSH: begin
            cur_code = flush_code;
            is_last  = x_last;
         end
         default: begin
            cur_code = gbtc_pkg::TILE_EMPTY;
            is_last  = 1'b0;
         end
      endcase

      emit    = (state_ff != ST_IDLE) && (!out_valid_ff || rsp_pop);
      take    = (state_ff == ST_IDLE) || (emit && is_last);
      job_pop = take && !job_empty;
   end

   always_comb begin
      state_in     = state_ff;
      ctrl_in      = ctrl_ff;
      up_in        = up_ff;
      mid_in       = mid_ff;
      x_in         = x_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      out_code_in  = out_code_ff;
      out_burst_in = out_burst_ff;
      out_frame_in = out_frame_ff;

      if (emit) begin
         out_valid_in = 1'b1;
         out_code_in  = cur_code;
         out_burst_in = is_last;
         out_frame_in = (state_ff == ST_FLUSH) && x_last;
         if (!is_last) begin
            case (state_ff)
               ST_A: begin
                  state_in = ctrl_ff.has_b ? ST_B : ST_FLUSH;
                  x_in     = '0;
               end
               ST_B: begin
                  state_in = ST_FLUSH;
                  x_in     = '0;
               end
               ST_FLUSH: begin
                  x_in = x_ff + CW'(1);
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
      end

      // Load the next job as soon as the current one has issued its last result.
      if (take) begin
         if (!job_empty) begin
            ctrl_in = job_ctrl;
            up_in   = job_up_row;
            mid_in  = job_mid_row;
            x_in    = '0;
            if (job_ctrl.has_a) state_in = ST_A;
            else if (job_ctrl.has_b) state_in = ST_B;
            else state_in = ST_FLUSH;
         end else begin
            state_in = ST_IDLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ctrl_ff      <= ctrl_in;
      up_ff        <= up_in;
      mid_ff       <= mid_in;
      x_ff         <= x_in;
      out_code_ff  <= out_code_in;
      out_burst_ff <= out_burst_in;
      out_frame_ff <= out_frame_in;
   end

   assign rsp_empty      = !out_valid_ff;
   assign rsp_tile_code  = out_code_ff;
   assign rsp_burst_last = out_burst_ff;
   assign rsp_frame_last = out_frame_ff;

endmodule

// ----- src/grid_border_tile_classifier_core.sv -----
// Channel   Direction  Handshake                  Payload
// req_      in         push / full                is_floor, frame_start
// rsp_      out        pop / empty                tile_code, burst_last, frame_last
// csr_      in         wen (no wait, no readback)  index, wdata
//
// The front takes one cell per cycle while the job queue has room and classifies the
// up to two cells it completes in that same cycle. The back issues one result per cycle
// while results are popped. The last cell of a frame also queues the final row, which
// the back walks one column a cycle while results are popped, so that request is
// followed by frame_width + 2 results at most. req_full rises only while the job
// queue holds QUEUE_DEPTH jobs. Reset is synchronous: row buffers clear to empty,
// counters to zero, width and height to 32; no clearing pass is needed.
`include "grid_border_tile_classifier_core_assert.svh"

module grid_border_tile_classifier_core #(
   parameter int MAX_WIDTH   = gbtc_pkg::MAX_WIDTH_DEFAULT,
   parameter int QUEUE_DEPTH = gbtc_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   // request side
   input  logic                                req_push,
   output logic                                req_full,
   input  logic                                req_is_floor,
   input  logic                                req_frame_start,
   // result side
   input  logic                                rsp_pop,
   output logic                                rsp_empty,
   output logic [gbtc_pkg::TILE_BITS-1:0]      rsp_tile_code,
   output logic                                rsp_burst_last,
   output logic                                rsp_frame_last,
   // configuration
   input  logic                                csr_wen,
   input  logic [gbtc_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [gbtc_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int CTRL_BITS = $bits(gbtc_pkg::job_ctrl_type);
   localparam int JOB_BITS = CTRL_BITS + 2 * MAX_WIDTH;

   // Front to queue
   logic                   q_push;
   gbtc_pkg::job_ctrl_type f_ctrl;
   logic [MAX_WIDTH-1:0]   f_up_row;
   logic [MAX_WIDTH-1:0]   f_mid_row;
   logic [WW-1:0]          width_eff;

   // Queue to back
   logic                   q_pop;
   logic                   q_full;
   logic                   q_empty;
   logic [JOB_BITS-1:0]    q_wdata;
   logic [JOB_BITS-1:0]    q_rdata;
   gbtc_pkg::job_ctrl_type b_ctrl;
   logic [MAX_WIDTH-1:0]   b_up_row;
   logic [MAX_WIDTH-1:0]   b_mid_row;

   // Hold requests off while the queue has no free slot.
   assign req_full = q_full;

   gbtc_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_is_floor    (req_is_floor),
      .req_frame_start (req_frame_start),
      .csr_wen         (csr_wen),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .job_full        (q_full),
      .job_push        (q_push),
      .job_ctrl        (f_ctrl),
      .job_up_row      (f_up_row),
      .job_mid_row     (f_mid_row),
      .width_eff       (width_eff)
   );

   // Pack the job: control word on top, then the two rows the flush needs.
   assign q_wdata   = {f_ctrl, f_up_row, f_mid_row};
   assign b_ctrl    = gbtc_pkg::job_ctrl_type'(q_rdata[JOB_BITS-1 -: CTRL_BITS]);
   assign b_up_row  = q_rdata[2*MAX_WIDTH-1 -: MAX_WIDTH];
   assign b_mid_row = q_rdata[MAX_WIDTH-1:0];

   gbtc_job_queue #(.DATA_BITS(JOB_BITS), .DEPTH(QUEUE_DEPTH)) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .wdata (q_wdata),
      .pop   (q_pop),
      .rdata (q_rdata),
      .full  (q_full),
      .empty (q_empty)
   );

   // The back drains jobs into a single output register.
   gbtc_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
      .clock          (clock),
      .reset          (reset),
      .job_empty      (q_empty),
      .job_ctrl       (b_ctrl),
      .job_up_row     (b_up_row),
      .job_mid_row    (b_mid_row),
      .width_eff      (width_eff),
      .job_pop        (q_pop),
      .rsp_pop        (rsp_pop),
      .rsp_empty      (rsp_empty),
      .rsp_tile_code  (rsp_tile_code),
      .rsp_burst_last (rsp_burst_last),
      .rsp_frame_last (rsp_frame_last)
   );

   // A queued job is never dropped by a write into a full queue.
   `GBTC_ASSERT_IMPL(a_push_not_full, clock, reset, q_push, !q_full)
   // The back never takes a job from an empty queue.
   `GBTC_ASSERT_IMPL(a_pop_not_empty, clock, reset, q_pop, !q_empty)
   // A pushed job is still waiting or being loaded in the next cycle.
   `GBTC_ASSERT_NEXT(a_push_visible, clock, reset, q_push, !q_empty)
   // The final cell of a frame closes the burst of its request.
   `GBTC_ASSERT_IMPL(a_frame_last_closes, clock, reset, !rsp_empty && rsp_frame_last,
                     rsp_burst_last)

endmodule
